/* sv/thermistor_adc_to_temperature_check_defines.svh */
// Assertion helpers shared by the thermistor block
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_CHECK_DEFINES_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_CHECK_DEFINES_SVH
`ifndef SYNTH
// check with reset masking
`define TAC_ASSERT(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) prop) \
		else $error("thermistor check failed");
// check that also holds while reset is applied
`define TAC_ASSERT_NR(lbl, ck, prop) \
	lbl: assert property (@(posedge ck) prop) else $error("thermistor check failed");
`else
`define TAC_ASSERT(lbl, ck, rstn, prop)
`define TAC_ASSERT_NR(lbl, ck, prop)
`endif
`endif

/* sv/tac_pkg.sv */
`default_nettype none
package tac_pkg;

	// resistance, Q.16 ohms
	localparam int RW = 52;
	localparam logic [RW-1:0] R_SAT = {RW{1'b1}};

	// log2 result: 6 integer bits, 24 fraction bits
	localparam int FRAC = 24;
	localparam int LOGW = 30;
	localparam logic [31:0] L_BIAS = 32'd134217728;
	localparam logic [29:0] LN2_Q30 = 30'd744261118;

	// linear sensor fits, slope Q.24, offset kelvin Q10.6
	localparam logic [21:0] KTY83_SLOPE = 22'd1705907;
	localparam logic [21:0] KTY84_SLOPE = 22'd2496292;
	localparam logic [15:0] KTY83_OFS = 16'd12928;
	localparam logic [15:0] KTY84_OFS = 16'd13824;

	// conversion methods
	localparam logic [1:0] METHOD_BETA  = 2'd0;
	localparam logic [1:0] METHOD_KTY83 = 2'd1;
	localparam logic [1:0] METHOD_KTY84 = 2'd2;

	// register indexes
	localparam logic [2:0] REG_LAYOUT = 3'd0;
	localparam logic [2:0] REG_METHOD = 3'd1;
	localparam logic [2:0] REG_RFIX   = 3'd2;
	localparam logic [2:0] REG_BETA   = 3'd3;
	localparam logic [2:0] REG_RINF   = 3'd4;
	localparam logic [2:0] REG_T_MIN  = 3'd5;
	localparam logic [2:0] REG_T_HOT  = 3'd6;
	localparam logic [2:0] REG_T_MAX  = 3'd7;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ROLLBACK = 2'd1;
	localparam logic [1:0] ST_OVERHEAT = 2'd2;

	typedef struct packed {
		logic [19:0] kty_q;
		logic        kty_big;
		logic        rq_zero;
		logic        r_sat;
	} log_sb_t;

	typedef struct packed {
		logic [19:0] kty_q;
		logic        kty_big;
		logic        rq_zero;
		logic        r_sat;
		logic        l_neg;
		logic        ovf;
	} quo_sb_t;

	typedef struct packed {
		logic [15:0] temperature_k;
		logic [1:0]  status;
		logic [15:0] overshoot;
		logic        saturated;
	} result_t;

endpackage
`default_nettype wire

/* sv/tac_div_pipe.sv */
`default_nettype none
// Restoring divider, one quotient bit per pipeline stage
module tac_div_pipe #(
	parameter int NW = 48,
	parameter int DW = 12,
	parameter int SBW = 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  logic [DW-1:0]  rem_init,
	input  logic [NW-1:0]  num,
	input  logic [DW-1:0]  den,
	input  logic [SBW-1:0] sb_in,
	output logic           out_valid,
	output logic [NW-1:0]  quo,
	output logic [SBW-1:0] sb_out
);

	logic           v_s   [NW];
	logic [DW-1:0]  rem_s [NW];
	logic [NW-1:0]  num_s [NW];
	logic [NW-1:0]  quo_s [NW];
	logic [DW-1:0]  den_s [NW];
	logic [SBW-1:0] sb_s  [NW];

	genvar j;
	for (j = 0; j < NW; j++) begin : g_stage
		logic           v_c;
		logic [DW-1:0]  rem_c;
		logic [NW-1:0]  num_c;
		logic [NW-1:0]  quo_c;
		logic [DW-1:0]  den_c;
		logic [SBW-1:0] sb_c;
		logic [DW:0]    trial;
		logic           take;

		if (j == 0) begin : g_in
			assign v_c   = in_valid;
			assign rem_c = rem_init;
			assign num_c = num;
			assign quo_c = '0;
			assign den_c = den;
			assign sb_c  = sb_in;
		end else begin : g_prev
			assign v_c   = v_s[j-1];
			assign rem_c = rem_s[j-1];
			assign num_c = num_s[j-1];
			assign quo_c = quo_s[j-1];
			assign den_c = den_s[j-1];
			assign sb_c  = sb_s[j-1];
		end

		// bring down next dividend bit, trial subtract
		assign trial = {rem_c, num_c[NW-1]};
		assign take  = trial >= {1'b0, den_c};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j] <= take ? DW'(trial - {1'b0, den_c}) : trial[DW-1:0];
				num_s[j] <= num_c << 1;
				quo_s[j] <= {quo_c[NW-2:0], take};
				den_s[j] <= den_c;
				sb_s[j]  <= sb_c;
			end
		end
	end

	assign out_valid = v_s[NW-1];
	assign quo       = quo_s[NW-1];
	assign sb_out    = sb_s[NW-1];

endmodule
`default_nettype wire

/* sv/tac_log2_pipe.sv */
`default_nettype none
// Two-lane log2 in Q.24: two normalize stages, then one squaring per stage
module tac_log2_pipe #(
	parameter int XW = 52,
	parameter int SBW = 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [XW-1:0]            x_a,
	input  logic [XW-1:0]            x_b,
	input  logic [SBW-1:0]           sb_in,
	output logic                     out_valid,
	output logic [tac_pkg::LOGW-1:0] log_a,
	output logic [tac_pkg::LOGW-1:0] log_b,
	output logic [SBW-1:0]           sb_out
);

	localparam int NST = tac_pkg::FRAC + 2;

	logic                     v_s  [NST];
	logic [SBW-1:0]           sb_s [NST];
	logic [tac_pkg::LOGW-1:0] log_w [2];

	genvar t, li, k;

	// valid and sideband chain
	for (t = 0; t < NST; t++) begin : g_ctl
		logic           v_c;
		logic [SBW-1:0] sb_c;
		if (t == 0) begin : g_in
			assign v_c  = in_valid;
			assign sb_c = sb_in;
		end else begin : g_prev
			assign v_c  = v_s[t-1];
			assign sb_c = sb_s[t-1];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[t] <= 1'b0;
			end else if (en) begin
				v_s[t] <= v_c;
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[t] <= sb_c;
			end
		end
	end

	for (li = 0; li < 2; li++) begin : g_lane
		logic [XW-1:0]              x_c;
		logic [63:0]                y1_c;
		logic [5:0]                 lz1_c;
		logic [63:0]                y_n1;
		logic [5:0]                 lz_n1;
		logic [63:0]                y2_c;
		logic [5:0]                 lz2_c;
		logic [31:0]                m_n2;
		logic [5:0]                 p_n2;
		logic [31:0]                m_s  [tac_pkg::FRAC];
		logic [tac_pkg::FRAC-1:0]   fr_s [tac_pkg::FRAC];
		logic [5:0]                 p_s  [tac_pkg::FRAC];

		if (li == 0) begin : g_a
			assign x_c = x_a;
		end else begin : g_b
			assign x_c = x_b;
		end

		// leading-zero search, coarse steps
		always_comb begin
			y1_c  = 64'(x_c);
			lz1_c = '0;
			if (y1_c[63:32] == '0) begin
				y1_c  = y1_c << 32;
				lz1_c = lz1_c + 6'd32;
			end
			if (y1_c[63:48] == '0) begin
				y1_c  = y1_c << 16;
				lz1_c = lz1_c + 6'd16;
			end
			if (y1_c[63:56] == '0) begin
				y1_c  = y1_c << 8;
				lz1_c = lz1_c + 6'd8;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_n1  <= y1_c;
				lz_n1 <= lz1_c;
			end
		end

		// leading-zero search, fine steps
		always_comb begin
			y2_c  = y_n1;
			lz2_c = lz_n1;
			if (y2_c[63:60] == '0) begin
				y2_c  = y2_c << 4;
				lz2_c = lz2_c + 6'd4;
			end
			if (y2_c[63:62] == '0) begin
				y2_c  = y2_c << 2;
				lz2_c = lz2_c + 6'd2;
			end
			if (!y2_c[63]) begin
				y2_c  = y2_c << 1;
				lz2_c = lz2_c + 6'd1;
			end
		end

		// mantissa in Q1.31, integer part of log2
		always_ff @(posedge clk) begin
			if (en) begin
				m_n2 <= y2_c[63:32];
				p_n2 <= 6'd63 - lz2_c;
			end
		end

		// one fraction bit per squaring
		for (k = 0; k < tac_pkg::FRAC; k++) begin : g_sq
			logic [31:0]              m_c;
			logic [tac_pkg::FRAC-1:0] fr_c;
			logic [5:0]               p_c;
			logic [63:0]              sq;
			logic [32:0]              sh;

			if (k == 0) begin : g_in
				assign m_c  = m_n2;
				assign fr_c = '0;
				assign p_c  = p_n2;
			end else begin : g_prev
				assign m_c  = m_s[k-1];
				assign fr_c = fr_s[k-1];
				assign p_c  = p_s[k-1];
			end

			assign sq = 64'(m_c) * 64'(m_c);
			assign sh = sq[63:31];

			always_ff @(posedge clk) begin
				if (en) begin
					m_s[k]  <= sh[32] ? sh[32:1] : sh[31:0];
					fr_s[k] <= {fr_c[tac_pkg::FRAC-2:0], sh[32]};
					p_s[k]  <= p_c;
				end
			end
		end

		assign log_w[li] = {p_s[tac_pkg::FRAC-1], fr_s[tac_pkg::FRAC-1]};
	end

	assign out_valid = v_s[NST-1];
	assign sb_out    = sb_s[NST-1];
	assign log_a     = log_w[0];
	assign log_b     = log_w[1];

endmodule
`default_nettype wire

/* sv/thermistor_adc_to_temperature_check.sv */
// Channel  | Direction | Handshake                 | Payload
// sample   | in        | sample_valid/sample_stall | adc_sample
// result   | out       | result_valid/result_stall | temperature_k, status, overshoot, saturated
// cfg      | in        | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// One sample per cycle while sample_stall is low. The path runs through the bit-serial
// resistance divider (NW stages, NW = max(48, 36 + bits of ADC_FULL_SCALE)), the
// 26-stage log2 pipe (2 normalize, 24 squaring) and the 16-stage temperature divider.
// arst_n clears all valid bits and loads the register reset values; cfg_ready is always high.
// The whole pipeline holds only when the two-entry output queue is full.
`default_nettype none
`include "thermistor_adc_to_temperature_check_defines.svh"
module thermistor_adc_to_temperature_check #(
	parameter int ADC_FULL_SCALE = 4095
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [11:0] adc_sample,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] temperature_k,
	output logic [1:0]  status,
	output logic [15:0] overshoot,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int FSW = $clog2(ADC_FULL_SCALE + 1);
	localparam int DW  = (FSW > 12) ? FSW : 12;
	localparam int NW  = (36 + FSW > 48) ? 36 + FSW : 48;
	localparam int P1W = 20 + FSW;
	localparam int RW  = tac_pkg::RW;
	localparam logic [FSW-1:0] FS_V = FSW'(ADC_FULL_SCALE);

	// configuration registers
	logic        layout_q;
	logic [1:0]  method_q;
	logic [19:0] rf_q;
	logic [15:0] beta_q;
	logic [31:0] rinf_q;
	logic [15:0] tmin_q;
	logic [15:0] thot_q;
	logic [15:0] tmax_q;

	logic adv;

	// operand stage
	logic [31:0]  prod0_c;
	logic [P1W-1:0] prod1_c;
	logic         esat_c;
	logic [NW-1:0] num_c;
	logic [DW-1:0] den_c;
	logic          v_s1;
	logic          esat_s1;
	logic [NW-1:0] num_s1;
	logic [DW-1:0] den_s1;

	// resistance stage
	logic          rdiv_v;
	logic [NW-1:0] rdiv_q;
	logic          rdiv_sat;
	logic [RW-1:0] q_c;
	logic [RW-1:0] b_c;
	logic [RW-1:0] rq_c;
	logic          rsat_c;
	logic          v_s2;
	logic [RW-1:0] rq_s2;
	logic          rsat_s2;

	// log2 and linear fit
	logic [RW-1:0]            xa_c;
	logic [RW-1:0]            xb_c;
	logic [21:0]              slope_c;
	logic [53:0]              kprod_c;
	tac_pkg::log_sb_t         log_sb_in;
	tac_pkg::log_sb_t         log_sb;
	logic                     log_v;
	logic [tac_pkg::LOGW-1:0] log_a;
	logic [tac_pkg::LOGW-1:0] log_b;

	// ln and temperature divide
	logic [31:0]      lsum_c;
	logic             v_s3;
	logic [29:0]      l_s3;
	logic             lneg_s3;
	tac_pkg::log_sb_t sb_s3;
	logic [59:0]      lnp_c;
	logic             v_s4;
	logic [29:0]      ln_s4;
	logic             lneg_s4;
	tac_pkg::log_sb_t sb_s4;
	logic [29:0]      bnum_c;
	tac_pkg::quo_sb_t tdiv_sb_in;
	tac_pkg::quo_sb_t tdiv_sb;
	logic             tdiv_v;
	logic [15:0]      tdiv_q;

	// select and classify
	logic [15:0] ofs_c;
	logic [20:0] kty_sum_c;
	logic [15:0] t_c;
	logic        tsat_c;
	logic        v_s5;
	logic [15:0] t_s5;
	logic        sat_s5;
	tac_pkg::result_t res_c;

	// output queue
	tac_pkg::result_t res_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] fifo_cnt_q;
	logic       push;
	logic       pop;

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= 1'b1;
			method_q <= tac_pkg::METHOD_BETA;
			rf_q     <= 20'd10000;
			beta_q   <= 16'd3435;
			rinf_q   <= 32'd1664300;
			tmin_q   <= 16'd14933;
			thot_q   <= 16'd22602;
			tmax_q   <= 16'd23882;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tac_pkg::REG_LAYOUT: layout_q <= cfg_data[0];
				tac_pkg::REG_METHOD: method_q <= cfg_data[1:0];
				tac_pkg::REG_RFIX:   rf_q     <= cfg_data[19:0];
				tac_pkg::REG_BETA:   beta_q   <= cfg_data[15:0];
				tac_pkg::REG_RINF:   rinf_q   <= cfg_data;
				tac_pkg::REG_T_MIN:  tmin_q   <= cfg_data[15:0];
				tac_pkg::REG_T_HOT:  thot_q   <= cfg_data[15:0];
				tac_pkg::REG_T_MAX:  tmax_q   <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// whole pipeline moves while the queue has room
	assign adv          = (fifo_cnt_q != 2'd2);
	assign sample_stall = !adv;

	// divider operands for the selected layout
	assign prod0_c = 32'(adc_sample) * 32'(rf_q);
	assign prod1_c = P1W'(rf_q) * P1W'(FS_V);

	always_comb begin
		if (!layout_q) begin
			esat_c = DW'(adc_sample) >= DW'(FS_V);
			num_c  = NW'({prod0_c, 16'b0});
			den_c  = DW'(FS_V) - DW'(adc_sample);
		end else begin
			esat_c = (adc_sample == '0);
			num_c  = NW'({prod1_c, 16'b0});
			den_c  = DW'(adc_sample);
		end
		if (esat_c) begin
			num_c = '0;
			den_c = DW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			esat_s1 <= esat_c;
			num_s1  <= num_c;
			den_s1  <= den_c;
		end
	end

	tac_div_pipe #(
		.NW (NW),
		.DW (DW),
		.SBW(1)
	) u_rdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s1),
		.rem_init ({DW{1'b0}}),
		.num      (num_s1),
		.den      (den_s1),
		.sb_in    (esat_s1),
		.out_valid(rdiv_v),
		.quo      (rdiv_q),
		.sb_out   (rdiv_sat)
	);

	// resistance in Q.16 ohms
	assign q_c = RW'(rdiv_q);
	assign b_c = RW'({rf_q, 16'b0});

	always_comb begin
		rq_c   = q_c;
		rsat_c = 1'b0;
		if (rdiv_sat) begin
			rq_c   = tac_pkg::R_SAT;
			rsat_c = 1'b1;
		end else if (layout_q) begin
			if (q_c < b_c) begin
				rq_c   = '0;
				rsat_c = 1'b1;
			end else begin
				rq_c = q_c - b_c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= rdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rq_s2   <= rq_c;
			rsat_s2 <= rsat_c;
		end
	end

	// log2 operands and linear-fit product
	assign xa_c    = (rq_s2 == '0) ? RW'(1) : rq_s2;
	assign xb_c    = (rinf_q == '0) ? RW'(1) : RW'(rinf_q);
	assign slope_c = (method_q == tac_pkg::METHOD_KTY84) ? tac_pkg::KTY84_SLOPE
	                                                     : tac_pkg::KTY83_SLOPE;
	assign kprod_c = 54'(rq_s2[31:0]) * 54'(slope_c);

	assign log_sb_in.kty_q   = kprod_c[53:34];
	assign log_sb_in.kty_big = |rq_s2[RW-1:32];
	assign log_sb_in.rq_zero = (rq_s2 == '0);
	assign log_sb_in.r_sat   = rsat_s2;

	tac_log2_pipe #(
		.XW (RW),
		.SBW($bits(tac_pkg::log_sb_t))
	) u_log (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s2),
		.x_a      (xa_c),
		.x_b      (xb_c),
		.sb_in    (log_sb_in),
		.out_valid(log_v),
		.log_a    (log_a),
		.log_b    (log_b),
		.sb_out   (log_sb)
	);

	// log2(R / r_inf) in Q.24
	assign lsum_c = 32'(log_a) - 32'(log_b) + tac_pkg::L_BIAS;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s3 <= log_v;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			l_s3    <= lsum_c[29:0];
			lneg_s3 <= lsum_c[31];
			sb_s3   <= log_sb;
		end
	end

	// natural log
	assign lnp_c = 60'(l_s3) * 60'(tac_pkg::LN2_Q30);

	always_ff @(posedge clk) begin
		if (adv) begin
			ln_s4   <= lnp_c[59:30];
			lneg_s4 <= lneg_s3;
			sb_s4   <= sb_s3;
		end
	end

	// beta / ln: quotient over 16 bits is flagged up front
	assign bnum_c = {beta_q, 14'b0};

	assign tdiv_sb_in.kty_q   = sb_s4.kty_q;
	assign tdiv_sb_in.kty_big = sb_s4.kty_big;
	assign tdiv_sb_in.rq_zero = sb_s4.rq_zero;
	assign tdiv_sb_in.r_sat   = sb_s4.r_sat;
	assign tdiv_sb_in.l_neg   = lneg_s4;
	assign tdiv_sb_in.ovf     = (bnum_c >= ln_s4);

	tac_div_pipe #(
		.NW (16),
		.DW (30),
		.SBW($bits(tac_pkg::quo_sb_t))
	) u_tdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s4),
		.rem_init (bnum_c),
		.num      (16'b0),
		.den      (ln_s4),
		.sb_in    (tdiv_sb_in),
		.out_valid(tdiv_v),
		.quo      (tdiv_q),
		.sb_out   (tdiv_sb)
	);

	// temperature select per method
	assign ofs_c     = (method_q == tac_pkg::METHOD_KTY84) ? tac_pkg::KTY84_OFS
	                                                       : tac_pkg::KTY83_OFS;
	assign kty_sum_c = 21'(tdiv_sb.kty_q) + 21'(ofs_c);

	always_comb begin
		t_c    = '0;
		tsat_c = 1'b0;
		case (method_q)
			tac_pkg::METHOD_BETA: begin
				if (tdiv_sb.rq_zero || rinf_q == '0 || tdiv_sb.l_neg) begin
					tsat_c = 1'b1;
				end else if (tdiv_sb.ovf) begin
					t_c    = 16'hFFFF;
					tsat_c = 1'b1;
				end else begin
					t_c = tdiv_q;
				end
			end
			tac_pkg::METHOD_KTY83, tac_pkg::METHOD_KTY84: begin
				if (tdiv_sb.kty_big || kty_sum_c[20:16] != '0) begin
					t_c    = 16'hFFFF;
					tsat_c = 1'b1;
				end else begin
					t_c = kty_sum_c[15:0];
				end
			end
			default: begin
				t_c    = '0;
				tsat_c = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= tdiv_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s5   <= t_c;
			sat_s5 <= tdiv_sb.r_sat | tsat_c;
		end
	end

	// limit check
	always_comb begin
		res_c.temperature_k = t_s5;
		res_c.saturated     = sat_s5;
		if (t_s5 <= tmin_q || t_s5 <= thot_q) begin
			res_c.status    = tac_pkg::ST_OK;
			res_c.overshoot = '0;
		end else if (t_s5 < tmax_q) begin
			res_c.status    = tac_pkg::ST_ROLLBACK;
			res_c.overshoot = t_s5 - thot_q;
		end else begin
			res_c.status    = tac_pkg::ST_OVERHEAT;
			res_c.overshoot = t_s5 - thot_q;
		end
	end

	// two-entry output queue
	assign push = v_s5 && adv;
	assign pop  = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q       <= 1'b0;
			rp_q       <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			if (push && !pop) begin
				fifo_cnt_q <= fifo_cnt_q + 2'd1;
			end else if (pop && !push) begin
				fifo_cnt_q <= fifo_cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			res_q[wp_q] <= res_c;
		end
	end

	assign result_valid  = (fifo_cnt_q != 2'd0);
	assign temperature_k = res_q[rp_q].temperature_k;
	assign status        = res_q[rp_q].status;
	assign overshoot     = res_q[rp_q].overshoot;
	assign saturated     = res_q[rp_q].saturated;

	// checks
	`TAC_ASSERT_NR(a_queue_ptrs, clk, (fifo_cnt_q != 2'd1) |-> (wp_q == rp_q))
	`TAC_ASSERT(a_hot_over, clk, arst_n, (result_valid && status != tac_pkg::ST_OK) |-> (overshoot != 16'd0 && temperature_k > thot_q))
	`TAC_ASSERT(a_ok_zero, clk, arst_n, (result_valid && status == tac_pkg::ST_OK) |-> (overshoot == 16'd0))
	`TAC_ASSERT(a_overheat_max, clk, arst_n, (result_valid && status == tac_pkg::ST_OVERHEAT) |-> (temperature_k >= tmax_q))

endmodule
`default_nettype wire

/* dv/tb_thermistor_adc_to_temperature_check.sv */
`timescale 1ns / 100ps
`default_nettype none

// Expected-reading store: one entry per accepted sample, checked in order
class temp_scoreboard;
	tac_pkg::result_t pending[$];
	int errors;
	int checked;

	function new();
		errors = 0;
		checked = 0;
	endfunction

	function void note_sample(tac_pkg::result_t exp_r);
		pending.push_back(exp_r);
	endfunction

	function void check_reading(tac_pkg::result_t got);
		tac_pkg::result_t exp_r;
		if (pending.size() == 0) begin
			$display("%0t: unexpected reading temp=%0d st=%0d over=%0d sat=%0d", $time,
				got.temperature_k, got.status, got.overshoot, got.saturated);
			errors++;
			return;
		end
		exp_r = pending.pop_front();
		checked++;
		if (got.temperature_k !== exp_r.temperature_k) begin
			$display("%0t: temperature_k expected %0d actual %0d", $time,
				exp_r.temperature_k, got.temperature_k);
			errors++;
		end
		if (got.status !== exp_r.status) begin
			$display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
			errors++;
		end
		if (got.overshoot !== exp_r.overshoot) begin
			$display("%0t: overshoot expected %0d actual %0d", $time,
				exp_r.overshoot, got.overshoot);
			errors++;
		end
		if (got.saturated !== exp_r.saturated) begin
			$display("%0t: saturated expected %0d actual %0d", $time,
				exp_r.saturated, got.saturated);
			errors++;
		end
	endfunction
endclass

module tb_thermistor_adc_to_temperature_check;

	localparam int FS = 4095;
	localparam int LATENCY = 96;
	localparam longint CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	logic [11:0] adc_sample = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic [15:0] temperature_k;
	logic [1:0]  status;
	logic [15:0] overshoot;
	logic        saturated;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// predictor copy of the registers
	logic        m_layout;
	logic [1:0]  m_method;
	logic [19:0] m_rfix;
	logic [15:0] m_beta;
	logic [31:0] m_rinf;
	logic [15:0] m_tmin, m_thot, m_tmax;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	longint cycles = 0;
	int samples_sent = 0;
	int settings_run = 0;

	temp_scoreboard sb;

	thermistor_adc_to_temperature_check #(.ADC_FULL_SCALE(FS)) dut (
		.clk(clk), .arst_n(arst_n),
		.sample_valid(sample_valid), .sample_stall(sample_stall), .adc_sample(adc_sample),
		.result_valid(result_valid), .result_stall(result_stall),
		.temperature_k(temperature_k), .status(status), .overshoot(overshoot),
		.saturated(saturated),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// log2 of x >= 1, unsigned Q.24, via repeated squaring of the mantissa
	function automatic logic [63:0] log2_fix(logic [63:0] x);
		int p;
		logic [63:0] m;
		logic [63:0] frac;
		p = 0;
		frac = 0;
		while (p < 63 && (x >> (p + 1)) != 0)
			p++;
		if (p >= 31)
			m = x >> (p - 31);
		else
			m = x << (31 - p);
		for (int i = 0; i < 24; i++) begin
			m = (m * m) >> 31;
			frac = frac << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return (64'(p) << 24) | frac;
	endfunction

	function automatic tac_pkg::result_t predict_reading(logic [11:0] adc_in);
		tac_pkg::result_t r;
		logic [63:0] adc, rq, t, a, b, ln, slope, off;
		logic signed [63:0] l;
		logic sat;
		logic [63:0] rsat;
		adc = 64'(adc_in);
		rsat = (64'd1 << 52) - 1;
		sat = 1'b0;
		t = 0;
		// sensor resistance
		if (m_layout == 1'b0) begin
			if (adc >= FS) begin
				rq = rsat;
				sat = 1'b1;
			end else begin
				rq = ((adc * 64'(m_rfix)) << 16) / (FS - adc);
			end
		end else begin
			if (adc == 0) begin
				rq = rsat;
				sat = 1'b1;
			end else begin
				a = ((64'(m_rfix) * FS) << 16) / adc;
				b = 64'(m_rfix) << 16;
				if (a < b) begin
					rq = 0;
					sat = 1'b1;
				end else begin
					rq = a - b;
					if (rq > rsat) begin
						rq = rsat;
						sat = 1'b1;
					end
				end
			end
		end
		// resistance to kelvin
		if (m_method == tac_pkg::METHOD_BETA) begin
			if (rq == 0 || m_rinf == 0) begin
				t = 0;
				sat = 1'b1;
			end else begin
				l = $signed(log2_fix(rq)) - $signed(log2_fix(64'(m_rinf))) + (64'sd8 << 24);
				if (l < 0) begin
					t = 0;
					sat = 1'b1;
				end else begin
					ln = (64'(l) * 64'(tac_pkg::LN2_Q30)) >> 30;
					if (ln == 0) begin
						t = 64'hFFFF;
						sat = 1'b1;
					end else begin
						t = (64'(m_beta) << 30) / ln;
					end
				end
			end
		end else if (m_method == tac_pkg::METHOD_KTY83 || m_method == tac_pkg::METHOD_KTY84) begin
			slope = (m_method == tac_pkg::METHOD_KTY83) ? 64'(tac_pkg::KTY83_SLOPE)
			                                           : 64'(tac_pkg::KTY84_SLOPE);
			off = (m_method == tac_pkg::METHOD_KTY83) ? 64'd202 : 64'd216;
			if ((rq >> 16) >= 65536) begin
				t = 64'hFFFF;
				sat = 1'b1;
			end else begin
				t = ((rq * slope) >> 34) + off * 64;
			end
		end
		if (t > 64'hFFFF) begin
			t = 64'hFFFF;
			sat = 1'b1;
		end
		// limit classification
		r.temperature_k = t[15:0];
		r.saturated = sat;
		if (t <= 64'(m_tmin) || t <= 64'(m_thot)) begin
			r.status = tac_pkg::ST_OK;
			r.overshoot = '0;
		end else begin
			r.status = (t < 64'(m_tmax)) ? tac_pkg::ST_ROLLBACK : tac_pkg::ST_OVERHEAT;
			r.overshoot = t[15:0] - m_thot;
		end
		return r;
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// result side: random stall, check on transfer
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_reading('{temperature_k, status, overshoot, saturated});
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			tac_pkg::REG_LAYOUT: m_layout = val[0];
			tac_pkg::REG_METHOD: m_method = val[1:0];
			tac_pkg::REG_RFIX:   m_rfix = val[19:0];
			tac_pkg::REG_BETA:   m_beta = val[15:0];
			tac_pkg::REG_RINF:   m_rinf = val;
			tac_pkg::REG_T_MIN:  m_tmin = val[15:0];
			tac_pkg::REG_T_HOT:  m_thot = val[15:0];
			tac_pkg::REG_T_MAX:  m_tmax = val[15:0];
			default: begin
			end
		endcase
	endtask

	// one sample transfer; valid stays high across back-to-back samples
	task automatic send_sample(logic [11:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		adc_sample <= v;
		sb.note_sample(predict_reading(v));
		samples_sent++;
		do @(posedge clk); while (sample_stall);
	endtask

	// after the last reading, let the pipe drain before touching registers
	task automatic wait_drained();
		sample_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	function automatic logic [11:0] pick_adc();
		int k;
		k = $urandom_range(9);
		if (k == 0)
			return 12'($urandom_range(3));
		if (k == 1)
			return 12'(FS - 2 + $urandom_range(2));
		return 12'($urandom);
	endfunction

	task automatic apply_setting();
		logic [31:0] rinf_v, rf_v;
		int e;
		e = $urandom_range(3);
		rf_v = (e == 0) ? 32'd1 : (e == 1) ? 32'hFFFFF : 32'($urandom_range(1, 'hFFFFF));
		write_reg(tac_pkg::REG_LAYOUT, 32'($urandom_range(1)));
		write_reg(tac_pkg::REG_METHOD, 32'($urandom_range(3)));
		write_reg(tac_pkg::REG_RFIX, rf_v);
		write_reg(tac_pkg::REG_BETA, (e == 1) ? 32'hFFFF : 32'($urandom_range(1, 65535)));
		rinf_v = (e == 0) ? 32'd1 : (e == 1) ? 32'hFFFF_FFFF : $urandom;
		write_reg(tac_pkg::REG_RINF, rinf_v);
		write_reg(tac_pkg::REG_T_MIN, (e == 2) ? 32'hFFFF : 32'($urandom_range(0, 65535)));
		write_reg(tac_pkg::REG_T_HOT, 32'($urandom_range(0, 65535)));
		write_reg(tac_pkg::REG_T_MAX, (e == 3) ? 32'd0 : 32'($urandom_range(0, 65535)));
		settings_run++;
	endtask

	initial begin
		logic [11:0] directed [$];
		sb = new();
		m_layout = 1'b1;
		m_method = tac_pkg::METHOD_BETA;
		m_rfix = 20'd10000;
		m_beta = 16'd3435;
		m_rinf = 32'd1664300;
		m_tmin = 16'd14933;
		m_thot = 16'd22602;
		m_tmax = 16'd23882;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset setting, then each method and layout over the edge samples
		directed = '{12'd0, 12'd1, 12'd2, 12'd2048, 12'd4094, 12'd4095, 12'hFFF, 12'd300};
		foreach (directed[i]) send_sample(directed[i]);
		for (int m = 0; m < 4; m++) begin
			wait_drained();
			write_reg(tac_pkg::REG_METHOD, 32'(m));
			write_reg(tac_pkg::REG_LAYOUT, 32'(m[0]));
			send_sample(12'd0);
			send_sample(12'd1);
			send_sample(12'd4095);
			send_sample(12'($urandom));
		end
		// tiny resistor pushes the log below zero; huge r_inf likewise
		wait_drained();
		write_reg(tac_pkg::REG_METHOD, 32'(tac_pkg::METHOD_BETA));
		write_reg(tac_pkg::REG_RFIX, 32'd1);
		write_reg(tac_pkg::REG_RINF, 32'hFFFF_FFFF);
		write_reg(tac_pkg::REG_T_MIN, 32'hFFFF);
		send_sample(12'd100);
		send_sample(12'd4000);
		wait_drained();

		// random phases with changing settings and idling profiles
		for (int ph = 0; ph < 16; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			apply_setting();
			repeat (75) send_sample(pick_adc());
			wait_drained();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		wait_drained();
		$display("Covered %0d samples over %0d register settings, %0d readings checked.",
			samples_sent, settings_run, sb.checked);
		$display("All layouts, all methods and the saturation edges were exercised.");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

`default_nettype wire
